>>> rtl/ssmf_pkg.sv
// Package for the state-space filter core: payload word types, sizes and codes.
// No dependencies.
`default_nettype none
package ssmf_pkg;
   localparam int MAX_STATES_DEF  = 64;
   localparam int MAX_INPUTS_DEF  = 8;
   localparam int MAX_OUTPUTS_DEF = 8;
   localparam int FRAC_BITS_DEF   = 24;
   localparam int ACC_W           = 80;

   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;
   localparam logic [1:0] SEL_D = 2'd3;

   localparam logic [2:0] MODE_GENERAL = 3'd0;
   localparam logic [2:0] MODE_UPPER   = 3'd1;
   localparam logic [2:0] MODE_DIAG    = 3'd2;
   localparam logic [2:0] MODE_TRIDIAG = 3'd3;
   localparam logic [2:0] MODE_HESS    = 3'd4;

   localparam logic [1:0] REG_STATES  = 2'd0;
   localparam logic [1:0] REG_INPUTS  = 2'd1;
   localparam logic [1:0] REG_OUTPUTS = 2'd2;
   localparam logic [1:0] REG_MODE    = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic [1:0]         matrix_select;
      logic [5:0]         row_index;
      logic [5:0]         col_index;
      logic signed [31:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         output_index;
      logic signed [31:0] output_value;
      logic               output_saturated;
      logic               output_last;
   } rsp_word_type;
endpackage
`default_nettype wire

>>> rtl/ssmf_mac.sv
// Multiply-accumulate unit with rounding and saturation for the filter core.
// Depends on ssmf_pkg.
`default_nettype none
module ssmf_mac import ssmf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                clear,
   input  wire                mul_en,
   input  wire signed [31:0]  op_a,
   input  wire signed [31:0]  op_b,
   output logic signed [31:0] result,
   output logic               result_sat
);
   logic signed [63:0]      prod_ff, prod_in;
   logic                    pv_ff, pv_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-FRAC_BITS-1:0] q;

   assign prod_in = op_a * op_b;
   assign pv_in   = mul_en;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff  <= pv_in;
         acc_ff <= acc_in;
      end
   end

   assign rnd = acc_ff + (ACC_W'(1) <<< (FRAC_BITS - 1));
   assign q   = rnd[ACC_W-1:FRAC_BITS];

   always_comb begin
      if (q > $signed((ACC_W-FRAC_BITS)'(32'sh7FFFFFFF))) begin
         result = 32'sh7FFFFFFF;
         result_sat = 1'b1;
      end else if (q < -$signed((ACC_W-FRAC_BITS)'(33'sh080000000))) begin
         result = 32'sh80000000;
         result_sat = 1'b1;
      end else begin
         result = q[31:0];
         result_sat = 1'b0;
      end
   end
endmodule
`default_nettype wire

>>> rtl/state_space_mimo_filter_core.sv
// State-space filter core: coefficient and state memories, sequencer, outputs.
// Depends on ssmf_pkg and ssmf_mac.
// Coefficient words and partial vectors are accepted only while idle. The last element of a vector
// holds off the input until every output row has been computed and sent and the state has been
// copied; result stalls lengthen that wait.
// Reset restores the registers and clears the element and state fill counts.
`default_nettype none
module state_space_mimo_filter_core import ssmf_pkg::*; #(
   parameter int MAX_STATES  = MAX_STATES_DEF,
   parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_word_type rsp_word,
   input  wire          csr_write_enable,
   input  wire  [1:0]   csr_index,
   input  wire  [6:0]   csr_write_data
);
   localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int RW = (MAX_STATES > MAX_OUTPUTS) ? SW : OW;
   localparam int KW = SW + 2;
   localparam int AAW = (MAX_STATES * MAX_STATES > 1) ?
                        $clog2(MAX_STATES * MAX_STATES) : 1;
   localparam int BAW = (MAX_STATES * MAX_INPUTS > 1) ?
                        $clog2(MAX_STATES * MAX_INPUTS) : 1;
   localparam int CAW = (MAX_OUTPUTS * MAX_STATES > 1) ?
                        $clog2(MAX_OUTPUTS * MAX_STATES) : 1;
   localparam int DAW = (MAX_OUTPUTS * MAX_INPUTS > 1) ?
                        $clog2(MAX_OUTPUTS * MAX_INPUTS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_X    = 3'd1;
   localparam logic [2:0] ST_U    = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;
   localparam logic [2:0] ST_COPY = 3'd5;

   // Registers
   logic [6:0] nreg_ff;
   logic [3:0] mreg_ff, preg_ff;
   logic [2:0] mode_ff;
   logic [3:0] ecnt_ff, ecnt_in;
   logic [2:0] st_ff, st_in;
   logic       ph_ff, ph_in;          // 0: state update rows, 1: output rows
   logic [RW-1:0] row_ff, row_in;
   logic [KW-1:0] k_ff, k_in;
   logic [2:0]    drain_ff, drain_in;
   logic          ssat_ff, ssat_in;
   logic [SW:0]   xfill_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   // Memories
   logic signed [31:0] mem_a [MAX_STATES*MAX_STATES];
   logic signed [31:0] mem_b [MAX_STATES*MAX_INPUTS];
   logic signed [31:0] mem_c [MAX_OUTPUTS*MAX_STATES];
   logic signed [31:0] mem_d [MAX_OUTPUTS*MAX_INPUTS];
   logic signed [31:0] mem_x [MAX_STATES];
   logic signed [31:0] mem_nx [MAX_STATES];
   logic signed [31:0] uvec [MAX_INPUTS];
   logic signed [31:0] rd_coef_ff, rd_var_ff;
   logic               rd_xzero_ff;

   // Clamped counts
   logic [8:0] n_c;
   logic [6:0] m_c, p_c;
   always_comb begin
      n_c = (nreg_ff == 7'd0) ? 9'd1 :
            (9'(nreg_ff) > 9'(MAX_STATES)) ? 9'(MAX_STATES) : 9'(nreg_ff);
      m_c = (mreg_ff == 4'd0) ? 7'd1 :
            (7'(mreg_ff) > 7'(MAX_INPUTS)) ? 7'(MAX_INPUTS) : 7'(mreg_ff);
      p_c = (preg_ff == 4'd0) ? 7'd1 :
            (7'(preg_ff) > 7'(MAX_OUTPUTS)) ? 7'(MAX_OUTPUTS) : 7'(preg_ff);
   end

   // Column range of the x walk
   logic [8:0] lo, hi, rowx;
   always_comb begin
      rowx = 9'(row_ff);
      lo = 9'd0;
      hi = n_c - 9'd1;
      if (!ph_ff) begin
         case (mode_ff)
            MODE_UPPER: lo = rowx;
            MODE_DIAG: begin
               lo = rowx;
               hi = rowx;
            end
            MODE_TRIDIAG: begin
               lo = (rowx != 9'd0) ? rowx - 9'd1 : 9'd0;
               hi = (rowx + 9'd1 < n_c) ? rowx + 9'd1 : n_c - 9'd1;
            end
            MODE_HESS: lo = (rowx != 9'd0) ? rowx - 9'd1 : 9'd0;
            default: ;
         endcase
      end
   end

   logic req_fire, coef_wr, samp, vec_done, rd_en, rd_x, last_row;
   assign req_ready = (st_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign coef_wr   = req_fire && !req_word.cmd;
   assign samp      = req_fire && req_word.cmd;
   assign vec_done  = samp && (7'(ecnt_ff) + 7'd1 >= m_c);
   assign last_row  = ph_ff ? (7'(row_ff) + 7'd1 >= p_c) : (9'(row_ff) + 9'd1 >= n_c);

   logic signed [31:0] mac_res;
   logic               mac_sat, mac_clr;

   always_comb begin
      st_in = st_ff;
      ph_in = ph_ff;
      row_in = row_ff;
      k_in = k_ff;
      drain_in = drain_ff;
      ssat_in = ssat_ff;
      ecnt_in = ecnt_ff;
      rd_en = 1'b0;
      rd_x = 1'b0;
      mac_clr = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      if (samp) begin
         ecnt_in = vec_done ? 4'd0 : ecnt_ff + 4'd1;
      end
      case (st_ff)
         ST_IDLE: begin
            if (vec_done) begin
               st_in = ST_X;
               ph_in = 1'b0;
               row_in = '0;
               ssat_in = 1'b0;
               mac_clr = 1'b1;
               k_in = '0;
            end
         end
         ST_X: begin
            if (9'(k_ff) < lo) begin
               k_in = KW'(lo);
            end else begin
               rd_en = 1'b1;
               rd_x = 1'b1;
               if (9'(k_ff) >= hi) begin
                  st_in = ST_U;
                  k_in = '0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_U: begin
            rd_en = 1'b1;
            if (7'(k_ff) + 7'd1 >= m_c) begin
               st_in = ST_FIN;
               drain_in = 3'd3;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (drain_ff != 3'd0) begin
               drain_in = drain_ff - 3'd1;
            end else if (!ph_ff) begin
               ssat_in = ssat_ff | mac_sat;
               mac_clr = 1'b1;
               k_in = '0;
               if (last_row) begin
                  ph_in = 1'b1;
                  row_in = '0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
               st_in = ST_X;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.output_index = 3'(row_ff);
               rsp_in.output_value = mac_res;
               rsp_in.output_saturated = ssat_ff | mac_sat;
               rsp_in.output_last = last_row;
               mac_clr = 1'b1;
               k_in = '0;
               if (last_row) begin
                  st_in = ST_COPY;
               end else begin
                  row_in = row_ff + 1'b1;
                  st_in = ST_X;
               end
            end
         end
         ST_COPY: begin
            if (9'(k_ff) + 9'd1 >= n_c) begin
               st_in = ST_OUT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nreg_ff <= 7'd1;
         mreg_ff <= 4'd1;
         preg_ff <= 4'd1;
         mode_ff <= MODE_GENERAL;
         st_ff <= ST_IDLE;
         ecnt_ff <= '0;
         ph_ff <= 1'b0;
         row_ff <= '0;
         k_ff <= '0;
         drain_ff <= '0;
         ssat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         xfill_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_STATES:  nreg_ff <= csr_write_data;
               REG_INPUTS:  mreg_ff <= csr_write_data[3:0];
               REG_OUTPUTS: preg_ff <= csr_write_data[3:0];
               REG_MODE:    mode_ff <= csr_write_data[2:0];
               default: ;
            endcase
         end
         st_ff <= st_in;
         ecnt_ff <= ecnt_in;
         ph_ff <= ph_in;
         row_ff <= row_in;
         k_ff <= k_in;
         drain_ff <= drain_in;
         ssat_ff <= ssat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_ff == ST_COPY && (SW+1)'(k_ff) >= xfill_ff) begin
            xfill_ff <= (SW+1)'(k_ff) + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Coefficient and vector memories
   logic [SW-1:0] kx;
   logic [IW-1:0] ku;
   assign kx = k_ff[SW-1:0];
   assign ku = k_ff[IW-1:0];

   logic [AAW-1:0] a_wr_addr, a_rd_addr;
   logic [BAW-1:0] b_wr_addr, b_rd_addr;
   logic [CAW-1:0] c_wr_addr, c_rd_addr;
   logic [DAW-1:0] d_wr_addr, d_rd_addr;
   assign a_wr_addr = AAW'(req_word.row_index) * AAW'(MAX_STATES) + AAW'(req_word.col_index);
   assign b_wr_addr = BAW'(req_word.row_index) * BAW'(MAX_INPUTS) + BAW'(req_word.col_index);
   assign c_wr_addr = CAW'(req_word.row_index) * CAW'(MAX_STATES) + CAW'(req_word.col_index);
   assign d_wr_addr = DAW'(req_word.row_index) * DAW'(MAX_INPUTS) + DAW'(req_word.col_index);
   assign a_rd_addr = AAW'(row_ff) * AAW'(MAX_STATES) + AAW'(kx);
   assign b_rd_addr = BAW'(row_ff) * BAW'(MAX_INPUTS) + BAW'(ku);
   assign c_rd_addr = CAW'(row_ff) * CAW'(MAX_STATES) + CAW'(kx);
   assign d_rd_addr = DAW'(row_ff) * DAW'(MAX_INPUTS) + DAW'(ku);

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         case (req_word.matrix_select)
            SEL_A: if (32'(req_word.row_index) < 32'(MAX_STATES) &&
                       32'(req_word.col_index) < 32'(MAX_STATES))
               mem_a[a_wr_addr] <= req_word.item_value;
            SEL_B: if (32'(req_word.row_index) < 32'(MAX_STATES) &&
                       32'(req_word.col_index) < 32'(MAX_INPUTS))
               mem_b[b_wr_addr] <= req_word.item_value;
            SEL_C: if (32'(req_word.row_index) < 32'(MAX_OUTPUTS) &&
                       32'(req_word.col_index) < 32'(MAX_STATES))
               mem_c[c_wr_addr] <= req_word.item_value;
            default: if (32'(req_word.row_index) < 32'(MAX_OUTPUTS) &&
                         32'(req_word.col_index) < 32'(MAX_INPUTS))
               mem_d[d_wr_addr] <= req_word.item_value;
         endcase
      end
      if (samp && 32'(ecnt_ff) < 32'(MAX_INPUTS)) begin
         uvec[ecnt_ff[IW-1:0]] <= req_word.item_value;
      end
      if (rd_en) begin
         if (rd_x) begin
            rd_coef_ff <= ph_ff ? mem_c[c_rd_addr] : mem_a[a_rd_addr];
            rd_var_ff  <= mem_x[kx];
         end else begin
            rd_coef_ff <= ph_ff ? mem_d[d_rd_addr] : mem_b[b_rd_addr];
            rd_var_ff  <= uvec[ku];
         end
      end
      if (st_ff == ST_FIN && drain_ff == 3'd0 && !ph_ff) begin
         mem_nx[row_ff[SW-1:0]] <= mac_res;
      end
   end

   // State copy: next-state is read into a register, and state is written from it in the cycle after.
   logic signed [31:0] cp_data_ff;
   logic [SW-1:0]      cp_addr_ff;
   logic               cp_we_ff;
   always_ff @(posedge clock) begin
      cp_data_ff <= mem_nx[kx];
      cp_addr_ff <= kx;
      if (cp_we_ff) begin
         mem_x[cp_addr_ff] <= cp_data_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_we_ff <= 1'b0;
         rd_xzero_ff <= 1'b0;
      end else begin
         cp_we_ff <= (st_ff == ST_COPY);
         if (rd_en) begin
            rd_xzero_ff <= rd_x && ((SW+1)'(kx) >= xfill_ff);
         end
      end
   end

   logic mul_v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else begin
         mul_v_ff <= rd_en;
      end
   end

   ssmf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock(clock),
      .reset(reset),
      .clear(mac_clr),
      .mul_en(mul_v_ff),
      .op_a(rd_coef_ff),
      .op_b(rd_xzero_ff ? 32'sd0 : rd_var_ff),
      .result(mac_res),
      .result_sat(mac_sat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule
`default_nettype wire
